// ----- rtl/spq_pkg.sv -----
// Package for the sorted priority queue: payload types, status codes and widths.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int PRIO_W    = 16;
    localparam int ID_W      = 16;
    localparam int AGE_W     = 8;
    localparam int COUNT_W   = 5;

    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef struct packed {
        mode_t                    mode;
        logic signed [PRIO_W-1:0] priority_req;
        logic [ID_W-1:0]          player_id;
        logic [AGE_W-1:0]         player_age;
    } in_t;

    typedef struct packed {
        status_t                  status;
        logic signed [PRIO_W-1:0] out_priority;
        logic [ID_W-1:0]          out_player_id;
        logic [AGE_W-1:0]         out_player_age;
        logic signed [PRIO_W-1:0] head_priority;
        logic [COUNT_W-1:0]       entry_count;
    } out_t;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [ID_W-1:0]          id;
        logic [AGE_W-1:0]         age;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/spq_cell.sv -----
// One queue cell: holds an entry, shifts right on insert and left on pop.
`timescale 1ns / 1ps
`default_nettype none
module spq_cell (
    input  wire logic                aclk,
    input  wire spq_pkg::cell_ctrl_t ctrl,
    input  wire spq_pkg::entry_t     new_entry,
    input  wire logic                valid,
    input  wire logic                left_keeps,
    input  wire spq_pkg::entry_t     left_entry,
    input  wire spq_pkg::entry_t     right_entry,
    output spq_pkg::entry_t          entry,
    output spq_pkg::entry_t          entry_next,
    output logic                     lt
);

    spq_pkg::entry_t entry_reg;

    assign lt    = valid && (entry_reg.prio < new_entry.prio);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.push) begin
            if (!lt) begin
                entry_next = left_keeps ? new_entry : left_entry;
            end
        end else if (ctrl.pop) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule
`default_nettype wire

// ----- rtl/sorted_priority_queue.sv -----
// Sorted priority queue (smallest priority first) built as a row of shifting cells.
// Input channel s_valid/s_ready/s_payload carries one transaction: a push of
// (priority, player id, age) or a pop of the head entry.
// Output channel m_valid/m_ready/m_payload returns exactly one result per input
// transaction: a status, the popped entry (zero unless popped), the head priority
// after the step and the entry count after the step.
// Every cell compares the pushed priority with its own entry in parallel and either
// keeps its entry, takes the new one, or takes its left neighbor's; a pop moves
// every entry one cell toward the head. The whole row updates together.
// The result appears in the output register in the cycle after acceptance.
// Throughput: one transaction per cycle while the receiver takes results; the
// single output register holds a result until it is taken, and s_ready is low only
// while that register is full and m_ready is low.
// Push on a full queue returns a full status; pop on an empty queue returns an
// empty status; the stored entries are unchanged in both cases.
// Reset (aresetn low, synchronous) empties the queue and clears the output valid.
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire spq_pkg::in_t   s_payload,
    output logic                m_valid,
    input  wire logic           m_ready,
    output spq_pkg::out_t       m_payload
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    spq_pkg::out_t    m_payload_reg;
    spq_pkg::out_t    m_payload_next;

    spq_pkg::entry_t     new_entry;
    spq_pkg::cell_ctrl_t ctrl;
    spq_pkg::entry_t     cell_entry [DEPTH];
    spq_pkg::entry_t     cell_next  [DEPTH];
    logic [DEPTH-1:0]    cell_lt;
    logic [DEPTH-1:0]    cell_valid;

    logic accept;
    logic is_push;
    logic full;
    logic empty;
    logic [CNT_W+spq_pkg::COUNT_W-1:0] count_ext;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign is_push   = (s_payload.mode == spq_pkg::MODE_PUSH);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign ctrl.push = accept && is_push && !full;
    assign ctrl.pop  = accept && !is_push && !empty;

    assign new_entry.prio = s_payload.priority_req;
    assign new_entry.id   = s_payload.player_id;
    assign new_entry.age  = s_payload.player_age;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        spq_pkg::entry_t left_entry;
        spq_pkg::entry_t right_entry;
        logic            left_keeps;

        assign cell_valid[i] = (CNT_W'(i) < count_reg);

        if (i == 0) begin : g_first
            assign left_entry = new_entry;
            assign left_keeps = 1'b1;
        end else begin : g_mid
            assign left_entry = cell_entry[i-1];
            assign left_keeps = cell_lt[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_entry = cell_entry[i];
        end else begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .valid       (cell_valid[i]),
            .left_keeps  (left_keeps),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .entry_next  (cell_next[i]),
            .lt          (cell_lt[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (ctrl.push) begin
            count_next = count_reg + 1'b1;
        end else if (ctrl.pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    assign count_ext = {{spq_pkg::COUNT_W{1'b0}}, count_next};

    always_comb begin
        m_payload_next                = '0;
        m_payload_next.entry_count    = count_ext[spq_pkg::COUNT_W-1:0];
        m_payload_next.head_priority  = (count_next != '0) ? cell_next[0].prio : '0;
        if (is_push) begin
            m_payload_next.status = full ? spq_pkg::ST_FULL : spq_pkg::ST_PUSHED;
        end else if (empty) begin
            m_payload_next.status = spq_pkg::ST_EMPTY;
        end else begin
            m_payload_next.status         = spq_pkg::ST_POPPED;
            m_payload_next.out_priority   = cell_entry[0].prio;
            m_payload_next.out_player_id  = cell_entry[0].id;
            m_payload_next.out_player_age = cell_entry[0].age;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(2)) |-> (cell_entry[0].prio <= cell_entry[1].prio))
        else $error("head entry out of order");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_push && !full) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not grow the queue");

    a_refused_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && ((is_push && full) || (!is_push && empty))) |=> $stable(count_reg))
        else $error("refused transaction changed the count");
`endif

endmodule
`default_nettype wire

// ----- verif/tb_sorted_priority_queue.sv -----
// Testbench for sorted_priority_queue: directed rows, then random push/pop traffic checked by a predictor.
`timescale 1ns / 1ps
module tb_sorted_priority_queue;

    localparam int Q_DEPTH = spq_pkg::DEPTH_DEF;
    localparam int N_RANDOM = 1300;
    localparam int DRAIN_PAUSE_AT = 650;

    typedef struct {
        spq_pkg::in_t  req;
        bit            pinned;
        spq_pkg::out_t want;
    } stim_row_t;

    typedef struct {
        bit            pinned;
        spq_pkg::out_t want;
    } pin_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    spq_pkg::in_t  s_payload = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    spq_pkg::out_t m_payload;

    spq_pkg::entry_t shadow_entries [Q_DEPTH];
    int unsigned     shadow_fill = 0;
    pin_t            pinned_results [$];
    spq_pkg::out_t   pending_results [$];
    stim_row_t       directed_rows [$];
    int              errors = 0;

    pin_t          acc_pin;
    spq_pkg::out_t acc_pred;
    spq_pkg::out_t got_want;

    sorted_priority_queue DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // Apply one transaction to the shadow queue and return the result it should give.
    function automatic spq_pkg::out_t queue_step_result(input spq_pkg::in_t req);
        spq_pkg::out_t r;
        int unsigned   pos;
        int unsigned   i;
        r = '0;
        if (req.mode == spq_pkg::MODE_PUSH) begin
            if (shadow_fill >= Q_DEPTH) begin
                r.status = spq_pkg::ST_FULL;
            end else begin
                pos = 0;
                while (pos < shadow_fill && shadow_entries[pos].prio < req.priority_req)
                    pos++;
                for (i = shadow_fill; i > pos; i--)
                    shadow_entries[i] = shadow_entries[i-1];
                shadow_entries[pos].prio = req.priority_req;
                shadow_entries[pos].id   = req.player_id;
                shadow_entries[pos].age  = req.player_age;
                shadow_fill++;
                r.status = spq_pkg::ST_PUSHED;
            end
        end else begin
            if (shadow_fill == 0) begin
                r.status = spq_pkg::ST_EMPTY;
            end else begin
                r.out_priority   = shadow_entries[0].prio;
                r.out_player_id  = shadow_entries[0].id;
                r.out_player_age = shadow_entries[0].age;
                for (i = 1; i < shadow_fill; i++)
                    shadow_entries[i-1] = shadow_entries[i];
                shadow_fill--;
                r.status = spq_pkg::ST_POPPED;
            end
        end
        r.head_priority = (shadow_fill != 0) ? shadow_entries[0].prio : '0;
        r.entry_count   = shadow_fill[spq_pkg::COUNT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                acc_pin  = pinned_results.pop_front();
                acc_pred = queue_step_result(s_payload);
                pending_results.push_back(acc_pin.pinned ? acc_pin.want : acc_pred);
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with nothing outstanding");
                    errors++;
                end else begin
                    got_want = pending_results.pop_front();
                    check_field("status", int'(got_want.status), int'(m_payload.status));
                    check_field("out_priority", int'(got_want.out_priority),
                                int'(m_payload.out_priority));
                    check_field("out_player_id", int'(got_want.out_player_id),
                                int'(m_payload.out_player_id));
                    check_field("out_player_age", int'(got_want.out_player_age),
                                int'(m_payload.out_player_age));
                    check_field("head_priority", int'(got_want.head_priority),
                                int'(m_payload.head_priority));
                    check_field("entry_count", int'(got_want.entry_count),
                                int'(m_payload.entry_count));
                end
            end
        end
    end

    task automatic send_request(input spq_pkg::in_t req, input bit pinned,
                                input spq_pkg::out_t want, input int unsigned gap);
        pin_t p;
        p.pinned = pinned;
        p.want   = want;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        pinned_results.push_back(p);
        s_valid   <= 1'b1;
        s_payload <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_results.size() != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    function automatic stim_row_t make_row(input spq_pkg::mode_t mode,
                                           input logic signed [15:0] prio,
                                           input logic [15:0] id, input logic [7:0] age,
                                           input bit pinned, input spq_pkg::out_t want);
        stim_row_t row;
        row.req.mode         = mode;
        row.req.priority_req = prio;
        row.req.player_id    = id;
        row.req.player_age   = age;
        row.pinned           = pinned;
        row.want             = want;
        return row;
    endfunction

    function automatic spq_pkg::in_t random_request(input int unsigned push_pct);
        spq_pkg::in_t req;
        int unsigned  sel;
        req.mode = ($urandom_range(0, 99) < push_pct) ? spq_pkg::MODE_PUSH : spq_pkg::MODE_POP;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            req.priority_req = 16'($signed($urandom_range(0, 16)) - 8);
        else if (sel < 8)
            req.priority_req = 16'($urandom);
        else if (sel == 8)
            req.priority_req = 16'sh7FFF;
        else
            req.priority_req = 16'sh8000;
        req.player_id  = 16'($urandom);
        req.player_age = 8'($urandom);
        return req;
    endfunction

    // Result side: random stalls per transaction, with stall-free stretches.
    initial begin
        int unsigned stall;
        int unsigned n_taken;
        n_taken = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = ((n_taken / 50) % 3 == 1) ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            n_taken++;
        end
    end

    initial begin
        int            fill_prio [15] = '{-32768, 32767, 0, -1, 1, 5, 5, 100, -100,
                                          32767, -32768, 7, 3, -5, 2};
        int unsigned   push_pct [4] = '{85, 50, 15, 60};
        int unsigned   gap;
        int            k;
        spq_pkg::out_t none;
        spq_pkg::in_t  req;

        none = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_rows.push_back(make_row(spq_pkg::MODE_POP, 16'sh1234, 16'hBEEF, 8'h5A, 1'b1,
            '{spq_pkg::ST_EMPTY, 16'sd0, 16'd0, 8'd0, 16'sd0, 5'd0}));
        directed_rows.push_back(make_row(spq_pkg::MODE_PUSH, 16'sh7FFF, 16'hFFFF, 8'hFF, 1'b1,
            '{spq_pkg::ST_PUSHED, 16'sd0, 16'd0, 8'd0, 16'sh7FFF, 5'd1}));
        directed_rows.push_back(make_row(spq_pkg::MODE_PUSH, 16'sh8000, 16'h0000, 8'h00, 1'b1,
            '{spq_pkg::ST_PUSHED, 16'sd0, 16'd0, 8'd0, 16'sh8000, 5'd2}));
        directed_rows.push_back(make_row(spq_pkg::MODE_POP, 16'sd0, 16'd0, 8'd0, 1'b1,
            '{spq_pkg::ST_POPPED, 16'sh8000, 16'h0000, 8'h00, 16'sh7FFF, 5'd1}));
        directed_rows.push_back(make_row(spq_pkg::MODE_POP, 16'sd0, 16'd0, 8'd0, 1'b1,
            '{spq_pkg::ST_POPPED, 16'sh7FFF, 16'hFFFF, 8'hFF, 16'sd0, 5'd0}));
        // equal priorities: newest one must come out first
        directed_rows.push_back(make_row(spq_pkg::MODE_PUSH, 16'sd5, 16'd1, 8'd10, 1'b0, none));
        directed_rows.push_back(make_row(spq_pkg::MODE_PUSH, 16'sd5, 16'd2, 8'd20, 1'b0, none));
        directed_rows.push_back(make_row(spq_pkg::MODE_POP, 16'sd0, 16'd0, 8'd0, 1'b0, none));
        for (k = 0; k < 15; k++)
            directed_rows.push_back(make_row(spq_pkg::MODE_PUSH, 16'(fill_prio[k]),
                                             16'(16'h100 + k), 8'(k * 17), 1'b0, none));
        // full queue refuses the push
        directed_rows.push_back(make_row(spq_pkg::MODE_PUSH, 16'sh8000, 16'hAAAA, 8'h55,
                                         1'b0, none));
        directed_rows.push_back(make_row(spq_pkg::MODE_POP, 16'sh7FFF, 16'hFFFF, 8'hFF,
                                         1'b0, none));

        foreach (directed_rows[i]) begin
            gap = ((i / 8) % 3 == 2) ? 0 : $urandom_range(0, 16);
            send_request(directed_rows[i].req, directed_rows[i].pinned,
                         directed_rows[i].want, gap);
        end

        for (k = 0; k < N_RANDOM; k++) begin
            if (k == DRAIN_PAUSE_AT)
                wait_for_drain();
            req = random_request(push_pct[(k / 80) % 4]);
            gap = ((k / 40) % 3 == 2) ? 0 : $urandom_range(0, 16);
            send_request(req, 1'b0, none, gap);
        end

        wait_for_drain();
        repeat (4) @(posedge aclk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
verif/tb_sorted_priority_queue.sv
